### design/ipt_pkg.sv
// ----------------------------------------------------------------------------
// ipt_pkg
// Shared types, character codes, status codes and helper functions for the
// address-to-text formatter.
// ----------------------------------------------------------------------------
package ipt_pkg;

  // Status codes carried with every result item.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_UNSUP   = 2'd2;

  // Address families.
  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  // ASCII codes used by the text generator.
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_AOFF  = 8'h57;  // 'a' minus ten
  localparam logic [7:0] CH_DOT   = 8'h2e;  // '.'
  localparam logic [7:0] CH_COLON = 8'h3a;  // ':'
  localparam logic [7:0] CH_F     = 8'h66;  // 'f'

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture the input item
    logic       restart;   // put the text cursor at the first character
    logic       step;      // advance the text cursor by one character
    logic       emit;      // present the current character as a result
    logic       err;       // present an error result
    logic [1:0] err_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;       // current character is the final one
    logic too_long;   // text with terminator overflows the buffer
    logic size_zero;  // buffer size is zero
    logic fam_bad;    // address family is not supported
  } sts_t;

  // Longest zero-group run of an IPv6 address.
  typedef struct packed {
    logic       found;
    logic [2:0] start;
    logic [3:0] stop;   // first group after the run, up to 8
  } run_t;

  // Finds the first longest run of set bits; bit i flags group i as zero.
  function automatic run_t find_zero_run(input logic [7:0] zf);
    run_t       r;
    logic [3:0] cur_start;
    logic [3:0] cur_len;
    logic [3:0] best_len;
    r.start   = 3'd0;
    r.found   = 1'b0;
    r.stop    = 4'd0;
    cur_start = 4'd0;
    cur_len   = 4'd0;
    best_len  = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (zf[i]) begin
        if (cur_len == 4'd0) begin
          cur_start = 4'(i);
        end
        cur_len = cur_len + 4'd1;
        if (cur_len > best_len) begin
          best_len = cur_len;
          r.start  = cur_start[2:0];
        end
      end else begin
        cur_len = 4'd0;
      end
    end
    r.found = (best_len != 4'd0);
    r.stop  = {1'b0, r.start} + best_len;
    return r;
  endfunction

  // Binary to three BCD digits, hundreds in the top nibble.
  function automatic logic [11:0] dec_digits(input logic [7:0] v);
    logic [11:0] b;
    b = 12'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[3:0] >= 4'd5) begin
        b[3:0] = b[3:0] + 4'd3;
      end
      if (b[7:4] >= 4'd5) begin
        b[7:4] = b[7:4] + 4'd3;
      end
      b = {b[10:0], v[i]};
    end
    return b;
  endfunction

endpackage

### design/ipt_ctrl.sv
// ----------------------------------------------------------------------------
// ipt_ctrl
// Controller: sequences the measuring pass, the size check and the output
// pass of one address.
// ----------------------------------------------------------------------------
module ipt_ctrl
  import ipt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_INIT  = 2'd1;
  localparam logic [1:0] S_COUNT = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.restart = 1'b1;
        if (sts.size_zero) begin
          cmd.err      = 1'b1;
          cmd.err_code = ST_NOSPACE;
          state_nxt    = S_IDLE;
        end else if (sts.fam_bad) begin
          cmd.err      = 1'b1;
          cmd.err_code = ST_UNSUP;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          if (sts.too_long) begin
            cmd.err      = 1'b1;
            cmd.err_code = ST_NOSPACE;
            state_nxt    = S_IDLE;
          end else begin
            cmd.restart = 1'b1;
            state_nxt   = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        cmd.step = 1'b1;
        cmd.emit = 1'b1;
        if (sts.last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // The init state always resolves in the following cycle, to counting or to idle.
  a_init_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INIT |=> state_r == S_COUNT || state_r == S_IDLE)
    else $error("init state did not resolve");

  // The final character of the output pass returns the block to idle.
  a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && sts.last |=> state_r == S_IDLE)
    else $error("output pass ran past the last character");

  // Measuring pass never shows results.
  a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COUNT |-> !cmd.emit)
    else $error("result shown during measuring pass");

endmodule

### design/ipt_dpath.sv
// ----------------------------------------------------------------------------
// ipt_dpath
// Datapath: input registers, address analysis, the character cursor that
// walks the text, the length counter and the result registers.
// ----------------------------------------------------------------------------
module ipt_dpath
  import ipt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_addr_hi,
  input  logic [63:0] in_addr_lo,
  input  logic [7:0]  in_buffer_size,
  output logic        out_valid,
  output logic [7:0]  out_char,
  output logic        out_last_char,
  output logic [1:0]  out_status
);

  // Text layout of the address.
  localparam logic [1:0] M_V4     = 2'd0;  // dotted decimal
  localparam logic [1:0] M_MAPPED = 2'd1;  // ::ffff:a.b.c.d
  localparam logic [1:0] M_COMPAT = 2'd2;  // ::a.b.c.d
  localparam logic [1:0] M_V6     = 2'd3;  // hex groups

  // What the cursor points at.
  localparam logic [2:0] K_PRE   = 3'd0;  // prefix character
  localparam logic [2:0] K_DEC   = 3'd1;  // decimal digit of an octet
  localparam logic [2:0] K_DOT   = 3'd2;  // dot after an octet
  localparam logic [2:0] K_HEX   = 3'd3;  // hex digit of a group
  localparam logic [2:0] K_COLON = 3'd4;  // colon after a group
  localparam logic [2:0] K_DC0   = 3'd5;  // first colon of the zero run
  localparam logic [2:0] K_DC1   = 3'd6;  // second colon of the zero run

  logic [1:0]  fam_r;
  logic [7:0]  size_r;
  logic [63:0] hi_r;
  logic [63:0] lo_r;
  logic [1:0]  mode_r;
  run_t        run_r;

  logic [2:0]  kind_r,  kind_nxt;
  logic [2:0]  idx_r,   idx_nxt;
  logic [1:0]  dig_r,   dig_nxt;
  logic        fresh_r, fresh_nxt;
  logic [2:0]  pre_last_r;
  logic [5:0]  len_r;

  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic        out_last_r;
  logic [1:0]  out_status_r;

  // Input analysis.
  logic [1:0]  mode_in;
  logic [7:0]  zero_in;
  logic [15:0] grp_in [8];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      grp_in[i]     = in_addr_hi[48 - 16 * i +: 16];
      grp_in[i + 4] = in_addr_lo[48 - 16 * i +: 16];
    end
    for (int i = 0; i < 8; i++) begin
      zero_in[i] = (grp_in[i] == 16'd0);
    end
    if (in_req_type == FAM_V4) begin
      mode_in = M_V4;
    end else if (in_addr_hi == 64'd0 && in_addr_lo[63:32] == 32'h0000ffff) begin
      mode_in = M_MAPPED;
    end else if (in_addr_hi == 64'd0 && in_addr_lo[63:32] == 32'd0
                 && in_addr_lo[31:0] > 32'd1) begin
      mode_in = M_COMPAT;
    end else begin
      mode_in = M_V6;
    end
  end

  // Current field and its digits.
  logic [7:0]  octet [4];
  logic [15:0] grp   [8];
  logic [7:0]  oct_cur;
  logic [15:0] grp_cur;
  logic [11:0] bcd;
  logic [1:0]  dec_first;
  logic [1:0]  hex_first;
  logic [1:0]  eff;
  logic [3:0]  digit;
  logic [7:0]  ch;
  logic        last;
  logic [2:0]  idx_inc;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      octet[i]  = lo_r[24 - 8 * i +: 8];
      grp[i]    = hi_r[48 - 16 * i +: 16];
      grp[i + 4] = lo_r[48 - 16 * i +: 16];
    end
    oct_cur = octet[idx_r[1:0]];
    grp_cur = grp[idx_r];
    bcd     = dec_digits(oct_cur);
    if (oct_cur >= 8'd100) begin
      dec_first = 2'd2;
    end else if (oct_cur >= 8'd10) begin
      dec_first = 2'd1;
    end else begin
      dec_first = 2'd0;
    end
    if (grp_cur[15:12] != 4'd0) begin
      hex_first = 2'd3;
    end else if (grp_cur[11:8] != 4'd0) begin
      hex_first = 2'd2;
    end else if (grp_cur[7:4] != 4'd0) begin
      hex_first = 2'd1;
    end else begin
      hex_first = 2'd0;
    end
    idx_inc = idx_r + 3'd1;

    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    dig_nxt   = dig_r;
    fresh_nxt = 1'b0;
    last      = 1'b0;
    eff       = 2'd0;
    digit     = 4'd0;
    ch        = CH_COLON;

    case (kind_r)
      K_PRE: begin
        // The prefix is "::ffff:" or "::".
        ch = (idx_r >= 3'd2 && idx_r <= 3'd5) ? CH_F : CH_COLON;
        if (idx_r == pre_last_r) begin
          kind_nxt  = K_DEC;
          idx_nxt   = 3'd0;
          fresh_nxt = 1'b1;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      K_DEC: begin
        eff   = fresh_r ? dec_first : dig_r;
        digit = bcd[{eff, 2'b00} +: 4];
        ch    = CH_ZERO + {4'd0, digit};
        if (eff == 2'd0) begin
          last     = (idx_r[1:0] == 2'd3);
          kind_nxt = K_DOT;
        end else begin
          dig_nxt = eff - 2'd1;
        end
      end
      K_DOT: begin
        ch        = CH_DOT;
        kind_nxt  = K_DEC;
        idx_nxt   = idx_inc;
        fresh_nxt = 1'b1;
      end
      K_HEX: begin
        eff   = fresh_r ? hex_first : dig_r;
        digit = grp_cur[{eff, 2'b00} +: 4];
        ch    = (digit < 4'd10) ? CH_ZERO + {4'd0, digit} : CH_AOFF + {4'd0, digit};
        if (eff == 2'd0) begin
          last = (idx_r == 3'd7);
          if (run_r.found && idx_inc == run_r.start) begin
            kind_nxt = K_DC0;
            idx_nxt  = idx_inc;
          end else begin
            kind_nxt = K_COLON;
          end
        end else begin
          dig_nxt = eff - 2'd1;
        end
      end
      K_COLON: begin
        kind_nxt  = K_HEX;
        idx_nxt   = idx_inc;
        fresh_nxt = 1'b1;
      end
      K_DC0: begin
        kind_nxt = K_DC1;
      end
      K_DC1: begin
        last      = (run_r.stop == 4'd8);
        kind_nxt  = K_HEX;
        idx_nxt   = run_r.stop[2:0];
        fresh_nxt = 1'b1;
      end
      default: begin
        kind_nxt = K_PRE;
      end
    endcase
  end

  // Input capture; payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fam_r  <= in_req_type;
      size_r <= in_buffer_size;
      hi_r   <= in_addr_hi;
      lo_r   <= in_addr_lo;
      mode_r <= mode_in;
      run_r  <= find_zero_run(zero_in);
    end
  end

  // Cursor and length counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r     <= K_PRE;
      idx_r      <= 3'd0;
      dig_r      <= 2'd0;
      fresh_r    <= 1'b0;
      pre_last_r <= 3'd0;
      len_r      <= 6'd0;
    end else if (cmd.restart) begin
      idx_r   <= 3'd0;
      dig_r   <= 2'd0;
      fresh_r <= 1'b1;
      len_r   <= 6'd0;
      case (mode_r)
        M_V4: begin
          kind_r <= K_DEC;
        end
        M_MAPPED: begin
          kind_r     <= K_PRE;
          pre_last_r <= 3'd6;
        end
        M_COMPAT: begin
          kind_r     <= K_PRE;
          pre_last_r <= 3'd1;
        end
        default: begin
          kind_r <= (run_r.found && run_r.start == 3'd0) ? K_DC0 : K_HEX;
        end
      endcase
    end else if (cmd.step) begin
      kind_r  <= kind_nxt;
      idx_r   <= idx_nxt;
      dig_r   <= dig_nxt;
      fresh_r <= fresh_nxt;
      len_r   <= len_r + 6'd1;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit || cmd.err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err) begin
      out_char_r   <= 8'd0;
      out_last_r   <= 1'b1;
      out_status_r <= cmd.err_code;
    end else if (cmd.emit) begin
      out_char_r   <= ch;
      out_last_r   <= last;
      out_status_r <= ST_OK;
    end
  end

  assign sts.last      = last;
  assign sts.too_long  = ({2'b00, len_r} + 8'd1) >= size_r;
  assign sts.size_zero = (size_r == 8'd0);
  assign sts.fam_bad   = (fam_r != FAM_V4) && (fam_r != FAM_V6);

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;
  assign out_status    = out_status_r;

  // An error result is always a single, final result.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_last_r)
    else $error("error result not marked last");

  // Text characters are never zero.
  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_OK |-> out_char_r != 8'd0)
    else $error("zero character in text");

  // No address text is longer than 39 characters.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> len_r < 6'd39)
    else $error("text length overflow");

endmodule

### design/ip_address_to_text.sv
// ----------------------------------------------------------------------------
// ip_address_to_text
// Formats an IPv4 or IPv6 address as text, one character per result item.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low. The block first walks
// the text once without output to measure it, checks the length plus the
// terminator against the buffer size, and then walks it again, showing one
// character per cycle on out_char with out_valid high for exactly one cycle;
// out_last_char marks the final character. The receiver cannot stall, so it
// must take every character in the cycle it appears. A text is at most 39
// characters long. A single character cursor, stepped once per cycle, walks
// the text in both passes; busy stays high through the init state, the
// measuring pass and the output pass, and the first character appears only
// after the measuring pass. A zero buffer size, an unsupported family or an
// overflowing text gives one result item with out_char zero, out_last_char
// high and the status code; for a zero size or a bad family it is registered
// from the init state, and busy falls on the same cycle. IPv6 text compresses
// the first longest run of zero groups, even a single group, to "::";
// IPv4-mapped and IPv4-compatible addresses end in dotted decimal.
module ip_address_to_text
  import ipt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_addr_hi,
  input  logic [63:0] in_addr_lo,
  input  logic [7:0]  in_buffer_size,
  output logic        out_valid,
  output logic [7:0]  out_char,
  output logic        out_last_char,
  output logic [1:0]  out_status
);

  // Commands flow from the controller; status flows back from the datapath.
  cmd_t cmd;
  sts_t sts;

  ipt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ipt_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_req_type),
    .in_addr_hi     (in_addr_hi),
    .in_addr_lo     (in_addr_lo),
    .in_buffer_size (in_buffer_size),
    .out_valid      (out_valid),
    .out_char       (out_char),
    .out_last_char  (out_last_char),
    .out_status     (out_status)
  );

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the address-to-text formatter. Address items are
// sent in bursts with random gaps. Every item is also formatted by a
// behavioral formatter in the bench, and each character strobed by the block
// is compared field by field with the oldest expected character.
// ----------------------------------------------------------------------------
module tb_top;
  import ipt_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RANDOM_ITEMS   = 350;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int MAX_REPORTS    = 40;

  // The package names only the two supported families; these are the rest.
  localparam logic [1:0] FAM_RSVD_A = 2'd2;
  localparam logic [1:0] FAM_RSVD_B = 2'd3;

  // One character of address text, or one error result.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [1:0] status;
  } char_result_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic        busy;
  logic [1:0]  in_req_type    = '0;
  logic [63:0] in_addr_hi     = '0;
  logic [63:0] in_addr_lo     = '0;
  logic [7:0]  in_buffer_size = '0;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        out_last_char;
  logic [1:0]  out_status;

  // Characters still owed by the block, oldest first.
  char_result_t expected_chars[$];
  // Scratch text built by the formatter for one address.
  logic [7:0]   text_buf[$];

  int fail_count      = 0;
  int results_checked = 0;
  int burst_left      = 0;
  int idle_cycles     = 0;

  ip_address_to_text uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_addr_hi     (in_addr_hi),
    .in_addr_lo     (in_addr_lo),
    .in_buffer_size (in_buffer_size),
    .out_valid      (out_valid),
    .out_char       (out_char),
    .out_last_char  (out_last_char),
    .out_status     (out_status)
  );

  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  // --------------------------------------------------------------------------
  // Formatter
  // --------------------------------------------------------------------------

  // Appends a 32-bit address in dotted decimal, first octet from bits 31:24.
  // Each octet is written without leading zeros.
  function automatic void put_dotted(input logic [31:0] a);
    logic [7:0] octet;
    for (int k = 3; k >= 0; k--) begin
      octet = a[8*k +: 8];
      if (octet >= 8'd100) text_buf.push_back(CH_ZERO + octet / 8'd100);
      if (octet >= 8'd10) text_buf.push_back(CH_ZERO + (octet / 8'd10) % 8'd10);
      text_buf.push_back(CH_ZERO + octet % 8'd10);
      if (k != 0) text_buf.push_back(CH_DOT);
    end
  endfunction

  // Builds the text of a supported address into text_buf.
  function automatic void build_text(input logic [1:0] fam, input logic [63:0] hi,
                                     input logic [63:0] lo);
    logic [15:0] grp[8];
    logic [3:0]  nib;
    bit          lead;
    int          best_start;
    int          best_len;
    int          run_start;
    int          i;
    text_buf.delete();
    best_start = -1;
    best_len   = 0;
    run_start  = -1;
    for (int g = 0; g < 4; g++) begin
      grp[g]     = hi[63 - 16*g -: 16];
      grp[g + 4] = lo[63 - 16*g -: 16];
    end
    if (fam == FAM_V4) begin
      put_dotted(lo[31:0]);
    end else if (hi == 64'd0 && lo[63:32] == 32'h0000_ffff) begin
      // IPv4-mapped: ::ffff: followed by the dotted quad.
      repeat (2) text_buf.push_back(CH_COLON);
      repeat (4) text_buf.push_back(CH_F);
      text_buf.push_back(CH_COLON);
      put_dotted(lo[31:0]);
    end else if (hi == 64'd0 && lo[63:32] == 32'd0 && lo[31:0] > 32'd1) begin
      // IPv4-compatible; the unspecified and loopback addresses fall through.
      repeat (2) text_buf.push_back(CH_COLON);
      put_dotted(lo[31:0]);
    end else begin
      // First longest run of zero groups, a single group included.
      for (int g = 0; g < 8; g++) begin
        if (grp[g] == 16'd0) begin
          if (run_start < 0) run_start = g;
          if (g - run_start + 1 > best_len) begin
            best_len   = g - run_start + 1;
            best_start = run_start;
          end
        end else begin
          run_start = -1;
        end
      end
      i = 0;
      while (i < 8) begin
        if (i == best_start) begin
          repeat (2) text_buf.push_back(CH_COLON);
          i += best_len;
        end else begin
          lead = 1'b0;
          for (int k = 3; k >= 0; k--) begin
            nib = grp[i][4*k +: 4];
            if (nib != 4'd0 || lead || k == 0) begin
              lead = 1'b1;
              text_buf.push_back((nib < 4'd10) ? CH_ZERO + nib : CH_AOFF + nib);
            end
          end
          i++;
          if (i < 8 && i != best_start) text_buf.push_back(CH_COLON);
        end
      end
    end
  endfunction

  // Queues the results that one accepted item must produce.
  function automatic void expect_item(input logic [1:0] fam, input logic [63:0] hi,
                                      input logic [63:0] lo, input logic [7:0] buf_size);
    char_result_t r;
    if (buf_size == 8'd0) begin
      r = '{ch: 8'd0, last: 1'b1, status: ST_NOSPACE};
      expected_chars.push_back(r);
    end else if (fam != FAM_V4 && fam != FAM_V6) begin
      r = '{ch: 8'd0, last: 1'b1, status: ST_UNSUP};
      expected_chars.push_back(r);
    end else begin
      build_text(fam, hi, lo);
      // The terminator counts against the buffer but is never sent.
      if (text_buf.size() + 1 > int'(buf_size)) begin
        r = '{ch: 8'd0, last: 1'b1, status: ST_NOSPACE};
        expected_chars.push_back(r);
      end else begin
        for (int k = 0; k < text_buf.size(); k++) begin
          r = '{ch: text_buf[k], last: (k == text_buf.size() - 1), status: ST_OK};
          expected_chars.push_back(r);
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Lowers start and lets the given number of cycles pass.
  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // The sender works in bursts. At the end of a burst it goes quiet for a
  // random time; short, medium and long gaps let start rise again at every
  // point of the block's measuring and output passes. Some bursts have no
  // gap at all, so start stays high across consecutive items.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0: gap = $urandom_range(1, 2);
        1: gap = $urandom_range(3, 20);
        2: gap = $urandom_range(21, 90);
        default: gap = 0;
      endcase
      if (gap != 0) pause_sender(gap);
      burst_left = ($urandom_range(0, 4) == 0) ? 20 : $urandom_range(1, 6);
    end
    burst_left--;
  endtask

  // Presents one address item and waits until the block takes it. Start is
  // left high so that a following item can go out without a gap.
  task automatic send_item(input logic [1:0] fam, input logic [63:0] hi,
                           input logic [63:0] lo, input logic [7:0] buf_size);
    pace_sender();
    start          <= 1'b1;
    in_req_type    <= fam;
    in_addr_hi     <= hi;
    in_addr_lo     <= lo;
    in_buffer_size <= buf_size;
    do @(posedge clk); while (busy !== 1'b0);
    expect_item(fam, hi, lo, buf_size);
  endtask

  // --------------------------------------------------------------------------
  // Checker
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t ns MISMATCH: %s", $time, msg);
  endtask

  // Outputs are sampled at the rising edge, before the block updates them,
  // so each strobed character is seen exactly once.
  always @(posedge clk) begin : check_results
    char_result_t want;
    if (rst_n && out_valid) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected result char=%02h last=%b status=%0d",
                                  out_char, out_last_char, out_status));
      end else begin
        want = expected_chars.pop_front();
        if (out_char !== want.ch)
          report_mismatch($sformatf("result %0d: char %02h, expected %02h",
                                    results_checked, out_char, want.ch));
        if (out_last_char !== want.last)
          report_mismatch($sformatf("result %0d: last %b, expected %b",
                                    results_checked, out_last_char, want.last));
        if (out_status !== want.status)
          report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                    results_checked, out_status, want.status));
      end
      results_checked++;
    end
  end

  // The watchdog ends a run in which neither an item nor a result has moved
  // for far longer than the slowest item plus the longest sender gap.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_chars.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Dotted decimal: all-zero and all-one addresses, one-, two- and three-digit
  // octets, exact fits and a buffer one byte short. The upper bits of both
  // halves carry junk that the block must ignore.
  task automatic test_ipv4_text();
    send_item(FAM_V4, 64'd0, 64'd0, 8'd8);
    send_item(FAM_V4, '1, '1, 8'd16);
    send_item(FAM_V4, 64'd0, 64'h0000_0000_0a64_09c8, 8'd12);
    send_item(FAM_V4, rand64(), 64'hdead_beef_0116_8504, 8'd255);
  endtask

  // IPv6 text: the unspecified and loopback addresses, the smallest
  // IPv4-compatible address, mapped and compatible forms, a single zero
  // group, two equal runs where the first must win, a longer later run, a
  // run at the end, every hex digit with a leading zero to drop, and the
  // longest possible text with an exact and a short buffer.
  task automatic test_ipv6_text();
    send_item(FAM_V6, 64'd0, 64'd0, 8'd3);
    send_item(FAM_V6, 64'd0, 64'd1, 8'd255);
    send_item(FAM_V6, 64'd0, 64'd2, 8'd255);
    send_item(FAM_V6, '1, '1, 8'd40);
    send_item(FAM_V6, '1, '1, 8'd39);
    send_item(FAM_V6, 64'd0, 64'h0000_ffff_0000_0000, 8'd255);
    send_item(FAM_V6, 64'd0, 64'h0000_ffff_c0a8_0101, 8'd255);
    send_item(FAM_V6, 64'd0, 64'h0000_0000_0a00_00ff, 8'd255);
    send_item(FAM_V6, 64'h0001_0000_0002_0003, 64'h0004_0005_0006_0007, 8'd255);
    send_item(FAM_V6, 64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004, 8'd255);
    send_item(FAM_V6, 64'h0001_0000_0002_0000, 64'h0000_0000_0003_0004, 8'd255);
    send_item(FAM_V6, 64'h1234_abcd_0000_0000, 64'd0, 8'd255);
    send_item(FAM_V6, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 8'd255);
    send_item(FAM_V6, 64'd0, 64'h0001_0000_0000_0000, 8'd255);
  endtask

  // A zero buffer wins over every family; the reserved families give the
  // unsupported status for any other size.
  task automatic test_error_results();
    send_item(FAM_V4, rand64(), rand64(), 8'd0);
    send_item(FAM_V6, rand64(), rand64(), 8'd0);
    send_item(FAM_RSVD_A, rand64(), rand64(), 8'd0);
    send_item(FAM_RSVD_B, rand64(), rand64(), 8'd0);
    send_item(FAM_RSVD_A, rand64(), rand64(), 8'd255);
    send_item(FAM_RSVD_B, rand64(), rand64(), 8'd1);
  endtask

  // A group with zero, one to four significant hex digits.
  function automatic logic [15:0] rand_group();
    case ($urandom_range(0, 5))
      0, 1: return 16'd0;
      2: return 16'($urandom_range(1, 15));
      3: return 16'($urandom_range(1, 255));
      4: return 16'($urandom_range(1, 4095));
      default: return 16'($urandom);
    endcase
  endfunction

  // Random addresses. IPv6 items favor zero-heavy layouts so that the
  // compression logic is exercised, plus the mapped and compatible forms
  // and addresses close to them. Buffer sizes are often placed around the
  // text length so that both sides of the fit check are hit.
  task automatic test_random_addresses();
    logic [1:0]   fam;
    logic [63:0]  hi;
    logic [63:0]  lo;
    logic [127:0] addr;
    logic [7:0]   buf_size;
    int           sel;
    int           fit;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      hi  = rand64();
      lo  = rand64();
      if (sel < 40) begin
        fam = FAM_V4;
      end else if (sel < 88) begin
        fam = FAM_V6;
        case ($urandom_range(0, 6))
          0: ;  // fully random, seldom any zero group
          1, 2: begin
            for (int g = 0; g < 8; g++) addr[127 - 16*g -: 16] = rand_group();
            hi = addr[127:64];
            lo = addr[63:0];
          end
          3: begin
            hi = 64'd0;
            lo = {32'h0000_ffff, $urandom};
          end
          4: begin
            hi = 64'd0;
            lo = {32'd0, ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 300))};
          end
          5: begin
            // Near the mapped and compatible prefixes without matching them.
            hi = ($urandom_range(0, 1) != 0) ? 64'd0 : 64'd1 << $urandom_range(0, 63);
            lo = {32'h0000_ffff ^ (32'd1 << $urandom_range(0, 31)), $urandom};
          end
          default: begin
            hi = 64'd0;
            lo = 64'($urandom_range(0, 3));
          end
        endcase
      end else begin
        fam = ($urandom_range(0, 1) != 0) ? FAM_RSVD_B : FAM_RSVD_A;
      end

      case ($urandom_range(0, 9))
        0: buf_size = 8'($urandom_range(0, 255));
        1: buf_size = 8'd0;
        2, 3, 4: begin
          if (fam == FAM_V4 || fam == FAM_V6) begin
            build_text(fam, hi, lo);
            fit      = text_buf.size() - 1 + $urandom_range(0, 3);
            buf_size = 8'(fit);
          end else begin
            buf_size = 8'($urandom_range(1, 255));
          end
        end
        default: buf_size = 8'($urandom_range(40, 255));
      endcase
      send_item(fam, hi, lo, buf_size);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_ipv4_text();
    test_ipv6_text();
    test_error_results();
    test_random_addresses();

    // All items are in; let the block finish the last one and then watch a
    // while longer for stray results.
    start <= 1'b0;
    while (expected_chars.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
design/ipt_pkg.sv
design/ipt_ctrl.sv
design/ipt_dpath.sv
design/ip_address_to_text.sv
verif/tb_top.sv
